// ===== hdl/lph_pkg.sv =====
// types, constants and helper functions shared by the hash table block
`default_nettype none

package lph_pkg;

    // table geometry
    localparam int unsigned NUM_SLOTS = 16;
    localparam int unsigned IDX_W      = $clog2(NUM_SLOTS);
    localparam int unsigned REM_W      = IDX_W + 1;
    localparam int unsigned CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam logic [REM_W-1:0] TS_REM = REM_W'(NUM_SLOTS);

    // field widths
    localparam int unsigned OP_W     = 2;
    localparam int unsigned KEY_W    = 31;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned SLOT_W   = 4;

    // home slot reduction: 2*key+3 taken apart in chunks, msb first
    localparam int unsigned HASH_BITS   = KEY_W + 2;
    localparam int unsigned HASH_STEP   = 8;
    localparam int unsigned HASH_CHUNKS = (HASH_BITS + HASH_STEP - 1) / HASH_STEP;
    localparam int unsigned HASH_W      = HASH_CHUNKS * HASH_STEP;
    localparam int unsigned CHUNK_W     = $clog2(HASH_CHUNKS);

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DEL_MISS  = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] key;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } out_t;

    // status from the hash unit to the sequencer
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] home;
    } hash_res_t;

    // restoring remainder over one chunk of bits, msb first
    function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] rem,
                                                  input logic [HASH_STEP-1:0] bits);
        logic [REM_W-1:0] t;
        logic [IDX_W-1:0] r;
        r = rem;
        for (int i = HASH_STEP - 1; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= TS_REM)
            begin
                t = t - TS_REM;
            end
            r = t[IDX_W-1:0];
        end
        return r;
    endfunction

    // slot index as reported: low four bits, zero extended for small tables
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = (IDX_W + SLOT_W)'(idx);
        return ext[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lph_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module lph_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/lph_hash.sv =====
// iterative home slot unit: (2*key+3) mod table size, one chunk per cycle
`default_nettype none

module lph_hash (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [lph_pkg::KEY_W-1:0] key,
    output lph_pkg::hash_res_t     res
);
    import lph_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CHUNK_W-1:0]    cnt_reg, cnt_next;
    logic [HASH_W-1:0]     val_reg, val_next;
    logic [IDX_W-1:0]      rem_reg, rem_next;
    logic [HASH_BITS-1:0]  h;

    localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(HASH_CHUNKS - 1);

    // 2*key+3 never overflows its width
    assign h = {1'b0, key, 1'b0} + HASH_BITS'(3);

    // sequencing of the shared remainder step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = HASH_W'(h);
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = mod_step(rem_reg, val_reg[HASH_W-1 -: HASH_STEP]);
            val_next = val_reg << HASH_STEP;
            cnt_next = cnt_reg + CHUNK_W'(1);
            if (cnt_reg == LAST_CHUNK)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        val_reg <= val_next;
        rem_reg <= rem_next;
    end

    assign res.done = done_reg;
    assign res.home = rem_reg;

    // a new key never arrives while a reduction is under way
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("hash start while busy");

    // done comes only at the end of a reduction
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("hash done without a reduction");

endmodule

`default_nettype wire

// ===== hdl/linear_probe_hash_table_unit.sv =====
// open addressing hash table with linear probing, top level
//
//   channel | valid    | stall     | payload
//   input   | in_valid | in_stall  | in_data  (operation, key)
//   output  | out_valid| out_stall | out_data (status, slot)
//
// steps: one item first has its home slot found by the hash unit, then
//   each probed slot takes a key ram read step and then a check step, up
//   to NUM_SLOTS probes, then the result goes to the output register.
//   the key ram's registered read port is why each probe needs a read step.
// reset: used and tombstone flags are flip-flops cleared at once; keys need
//   no clearing since a key is only read from a used slot.
// stalls: the result sits in an output register, so the next item is taken
//   while it waits; that item stalls only at its own result step.
// operation code 3 is taken and dropped with no result.
`default_nettype none

module linear_probe_hash_table_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  lph_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output lph_pkg::out_t out_data
);
    import lph_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_HASH   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(NUM_SLOTS - 1);

    logic [2:0]            state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [NUM_SLOTS-1:0]  used_reg, used_next;
    logic [NUM_SLOTS-1:0]  del_reg, del_next;
    out_t                  res_reg, res_next;
    out_t                  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  hash_start;
    hash_res_t             hres;
    logic                  ram_we;
    logic [KEY_W-1:0]      ram_rdata;

    logic                  cur_used;
    logic                  cur_del;
    logic                  key_hit;
    logic [REM_W-1:0]      idx_inc;
    logic [IDX_W-1:0]      idx_wrap;
    logic [STATUS_W-1:0]   miss_status;

    // home slot unit
    lph_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_reg),
        .res   (hres)
    );

    // key store
    lph_ram #(
        .WIDTH (KEY_W),
        .DEPTH (NUM_SLOTS)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (key_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // probe slot decode
    assign cur_used    = used_reg[idx_reg];
    assign cur_del     = del_reg[idx_reg];
    assign key_hit     = ram_rdata == key_reg;
    assign idx_inc     = {1'b0, idx_reg} + REM_W'(1);
    assign idx_wrap    = (idx_inc == TS_REM) ? '0 : idx_inc[IDX_W-1:0];
    assign miss_status = (op_reg == OP_SEARCH) ? ST_NOT_FOUND : ST_DEL_MISS;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        used_next      = used_reg;
        del_next       = del_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        hash_start     = 1'b0;
        ram_we         = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_data.operation != OP_NOP)
                begin
                    op_next    = in_data.operation;
                    key_next   = in_data.key;
                    cnt_next   = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                // first cycle of the step kicks off the reduction
                if (cnt_reg == '0)
                begin
                    hash_start = 1'b1;
                    cnt_next   = CNT_W'(1);
                end
                if (hres.done)
                begin
                    idx_next   = hres.home;
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_RESULT;
                if (op_reg == OP_INSERT && (!cur_used || cur_del || key_hit))
                begin
                    ram_we             = 1'b1;
                    used_next[idx_reg] = 1'b1;
                    del_next[idx_reg]  = 1'b0;
                    res_next.status    = ST_INSERTED;
                    res_next.slot      = slot_of(idx_reg);
                end
                else if (op_reg != OP_INSERT && !cur_used)
                begin
                    res_next.status = miss_status;
                    res_next.slot   = '0;
                end
                else if (op_reg != OP_INSERT && !cur_del && key_hit)
                begin
                    if (op_reg == OP_DELETE)
                    begin
                        del_next[idx_reg] = 1'b1;
                        res_next.status   = ST_DELETED;
                    end
                    else
                    begin
                        res_next.status = ST_FOUND;
                    end
                    res_next.slot = slot_of(idx_reg);
                end
                else if (cnt_reg == LAST_PROBE)
                begin
                    res_next.status = (op_reg == OP_INSERT) ? ST_FULL : miss_status;
                    res_next.slot   = '0;
                end
                else
                begin
                    idx_next   = idx_wrap;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            del_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            del_reg       <= del_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // the hash unit reports only while the sequencer waits for it
    a_hash_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        hres.done |-> state_reg == ST_HASH)
        else $error("hash done outside hash step");

    // a slot check never runs past the last probe
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> cnt_reg <= LAST_PROBE)
        else $error("probe count past table size");

    // an insert leaves its slot used and live
    a_insert_live: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> used_reg[$past(idx_reg)] && !del_reg[$past(idx_reg)])
        else $error("inserted slot not live");

    // a new beat appears only from the result step
    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && !out_stall) && !$past(out_valid_reg))
            |-> $past(state_reg) == ST_RESULT)
        else $error("output beat without result step");

endmodule

`default_nettype wire
